// File: hdl/cov_pkg.sv
// types and constants shared by the change-of-value monitor
`timescale 1ns / 1ps

package cov_pkg;

    // action codes of an input item
    localparam logic [1:0] ACT_START  = 2'd0;
    localparam logic [1:0] ACT_SAMPLE = 2'd1;
    localparam logic [1:0] ACT_FINISH = 2'd2;
    localparam logic [1:0] ACT_REPORT = 2'd3;

    // value type codes
    localparam logic [1:0] VT_BIT   = 2'd0;
    localparam logic [1:0] VT_FLOAT = 2'd1;
    localparam logic [1:0] VT_S32   = 2'd2;
    localparam logic [1:0] VT_U32   = 2'd3;

    // result kinds
    localparam logic [2:0] KIND_ACK    = 3'd0;
    localparam logic [2:0] KIND_COUNT  = 3'd1;
    localparam logic [2:0] KIND_BEGIN  = 3'd2;
    localparam logic [2:0] KIND_MEMBER = 3'd3;
    localparam logic [2:0] KIND_END    = 3'd4;

    // configuration register indexes
    localparam logic [2:0] CFG_MEMBER_COUNT = 3'd0;
    localparam logic [2:0] CFG_MONITOR_MASK = 3'd1;
    localparam logic [2:0] CFG_GROUP_MODE   = 3'd2;
    localparam logic [2:0] CFG_EPS_ZERO     = 3'd3;
    localparam logic [2:0] CFG_EPS_ONE      = 3'd4;
    localparam logic [2:0] CFG_EPS_TWO      = 3'd5;
    localparam logic [2:0] CFG_EPS_THREE    = 3'd6;

    localparam int CFG_DATA_W = 63;
    localparam int VALUE_W    = 64;

    typedef struct packed {
        logic [1:0]         action;
        logic [4:0]         member_index;
        logic [1:0]         value_type;
        logic signed [63:0] sample;
        logic [1:0]         eps_select;
        logic               report_every;
    } item_t;

    typedef struct packed {
        logic [2:0] kind;
        logic [4:0] member_out;
        logic       changed;
        logic [5:0] change_total;
        logic       last;
    } result_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIFF,
        ST_JUDGE,
        ST_FINISH,
        ST_REP_BEGIN,
        ST_REP_WALK
    } state_t;

endpackage

// File: hdl/cov_track.sv
// tracked value store: registered synchronous read, zero until first written
`timescale 1ns / 1ps

module cov_track #(
    parameter int DEPTH = 32,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        rd_en,
    input  logic [AW-1:0]               rd_addr,
    output logic [cov_pkg::VALUE_W-1:0] rd_data,
    input  logic                        wr_en,
    input  logic [AW-1:0]               wr_addr,
    input  logic [cov_pkg::VALUE_W-1:0] wr_data
);

    logic [cov_pkg::VALUE_W-1:0] mem [DEPTH];
    logic [cov_pkg::VALUE_W-1:0] rd_data_reg;
    logic [DEPTH-1:0]            valid_reg;
    logic                        rd_valid_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // per-entry valid bits stand in for the all-zero reset of the store
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
        end
    end

    assign rd_data = rd_valid_reg ? rd_data_reg : '0;

endmodule

// File: hdl/change_of_value_monitor.sv
// change-of-value monitor top level: command decode, compare and report walk
`timescale 1ns / 1ps

// usage
//   input: an item is taken at a rising edge with start high and busy low;
//   start scan clears the change map and count and gives no result
//   results: at most one per cycle on result, marked by result_valid for one cycle;
//   the receiver has no way to hold them off, so each transfer is final
//   configuration: cfg_we, cfg_index, cfg_data are to be written by the user
//   only while the block is idle; the block itself does not enforce this
// sequence
//   sample: the tracking memory read, the registered absolute difference and
//   the compare-and-write-back step come before the ack; busy until the ack
//   shows, so a new sample is taken only once the last one is through
//   finish scan: the count is registered out of the finish state
//   report: begin, then a walk over each member below the effective count
//   (skipped members still take a step), then end; busy until end shows
// reset
//   control state and configuration clear at once; tracked values read as
//   zero through per-entry valid bits, so no clearing pass is needed
module change_of_value_monitor #(
    parameter int MAX_MEMBERS = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  cov_pkg::item_t                item,
    output logic                          result_valid,
    output cov_pkg::result_t              result,
    input  logic                          cfg_we,
    input  logic [2:0]                    cfg_index,
    input  logic [cov_pkg::CFG_DATA_W-1:0] cfg_data
);

    // tracking depth: member indexes are five bits wide
    localparam int DEPTH = (MAX_MEMBERS < 32) ? MAX_MEMBERS : 32;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [5:0] CAP = 6'(DEPTH);
    localparam logic [5:0] COUNT_SAT = 6'd32;

    // configuration
    logic [5:0]                    member_count_reg;
    logic [31:0]                   monitor_mask_reg;
    logic [2:0]                    group_mode_reg;
    logic [cov_pkg::CFG_DATA_W-1:0] eps_reg [4];

    // scan state
    cov_pkg::state_t state_reg, state_next;
    logic [31:0] change_map_reg, change_map_next;
    logic [5:0]  change_count_reg, change_count_next;

    // item held during its work
    logic [4:0]  idx_reg;
    logic [1:0]  type_reg;
    logic [63:0] sample_reg;
    logic [1:0]  sel_reg;
    logic        watched_reg;
    logic        all_reg;
    logic [31:0] t_reg;
    logic [63:0] d_reg, d_next;
    logic [5:0]  walk_reg, walk_next;

    // output register
    logic             out_valid_reg, out_valid_next;
    cov_pkg::result_t out_reg, out_next;

    // memory side
    logic [63:0] rd_data;
    logic        mem_wr_en;
    logic [63:0] mem_wr_data;
    logic        accept;

    // derived group figures
    logic [5:0]  eff_count;
    logic [31:0] range_mask;
    logic        any_watched;
    logic        active;
    logic        in_watched;

    // judge logic
    logic        chg;
    logic [63:0] nv;
    logic        s_ge;
    logic        member_bit;

    assign accept = start && (state_reg == cov_pkg::ST_IDLE);
    assign busy   = (state_reg != cov_pkg::ST_IDLE);

    assign eff_count   = (member_count_reg > CAP) ? CAP : member_count_reg;
    assign range_mask  = ~({32{1'b1}} << eff_count);
    assign any_watched = (eff_count != 6'd0)
                         && (group_mode_reg[0] || ((monitor_mask_reg & range_mask) != 32'd0));
    assign active      = group_mode_reg[1] || group_mode_reg[2] || any_watched;
    assign in_watched  = ({1'b0, item.member_index} < eff_count)
                         && (monitor_mask_reg[item.member_index] || group_mode_reg[0]);

    cov_track #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_track (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (accept),
        .rd_addr (item.member_index[AW-1:0]),
        .rd_data (rd_data),
        .wr_en   (mem_wr_en),
        .wr_addr (idx_reg[AW-1:0]),
        .wr_data (mem_wr_data)
    );

    // absolute difference of signed q32.32 values, exact in 64 bits
    always_comb
    begin
        s_ge   = ($signed(sample_reg) >= $signed(rd_data));
        d_next = s_ge ? (sample_reg - rd_data) : (rd_data - sample_reg);
    end

    // change decision by type
    always_comb
    begin
        case (type_reg)
            cov_pkg::VT_BIT:
            begin
                nv  = {63'd0, (sample_reg != 64'd0)};
                chg = (t_reg[0] != nv[0]);
            end
            cov_pkg::VT_FLOAT:
            begin
                nv  = sample_reg;
                chg = (d_reg > {1'b0, eps_reg[sel_reg]});
            end
            cov_pkg::VT_S32:
            begin
                nv  = {{32{sample_reg[31]}}, sample_reg[31:0]};
                chg = (t_reg[31:0] != sample_reg[31:0]);
            end
            default:
            begin
                nv  = {32'd0, sample_reg[31:0]};
                chg = (t_reg[31:0] != sample_reg[31:0]);
            end
        endcase
    end

    assign member_bit  = change_map_reg[walk_reg[4:0]];
    assign mem_wr_data = nv;

    // next state and outputs
    always_comb
    begin
        state_next        = state_reg;
        change_map_next   = change_map_reg;
        change_count_next = change_count_reg;
        walk_next         = walk_reg;
        out_valid_next    = 1'b0;
        out_next          = '0;
        mem_wr_en         = 1'b0;

        unique case (state_reg)
            cov_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (item.action)
                        cov_pkg::ACT_START:
                        begin
                            change_map_next   = 32'd0;
                            change_count_next = 6'd0;
                        end
                        cov_pkg::ACT_SAMPLE:
                        begin
                            state_next = cov_pkg::ST_DIFF;
                        end
                        cov_pkg::ACT_FINISH:
                        begin
                            state_next = cov_pkg::ST_FINISH;
                        end
                        default:
                        begin
                            state_next = cov_pkg::ST_REP_BEGIN;
                            walk_next  = 6'd0;
                        end
                    endcase
                end
            end
            cov_pkg::ST_DIFF:
            begin
                state_next = cov_pkg::ST_JUDGE;
            end
            cov_pkg::ST_JUDGE:
            begin
                state_next = cov_pkg::ST_IDLE;
                if (watched_reg && chg)
                begin
                    mem_wr_en                = 1'b1;
                    change_map_next[idx_reg] = 1'b1;
                    if (change_count_reg < COUNT_SAT)
                    begin
                        change_count_next = change_count_reg + 6'd1;
                    end
                end
                out_valid_next        = 1'b1;
                out_next.kind         = cov_pkg::KIND_ACK;
                out_next.member_out   = idx_reg;
                out_next.changed      = watched_reg && chg;
                out_next.change_total = change_count_next;
                out_next.last         = 1'b1;
            end
            cov_pkg::ST_FINISH:
            begin
                state_next            = cov_pkg::ST_IDLE;
                out_valid_next        = 1'b1;
                out_next.kind         = cov_pkg::KIND_COUNT;
                out_next.change_total = active ? change_count_reg : 6'd1;
                out_next.last         = 1'b1;
            end
            cov_pkg::ST_REP_BEGIN:
            begin
                state_next            = cov_pkg::ST_REP_WALK;
                out_valid_next        = 1'b1;
                out_next.kind         = cov_pkg::KIND_BEGIN;
                out_next.change_total = change_count_reg;
            end
            cov_pkg::ST_REP_WALK:
            begin
                out_next.change_total = change_count_reg;
                if (walk_reg < eff_count)
                begin
                    walk_next = walk_reg + 6'd1;
                    if (all_reg || member_bit)
                    begin
                        out_valid_next      = 1'b1;
                        out_next.kind       = cov_pkg::KIND_MEMBER;
                        out_next.member_out = walk_reg[4:0];
                        out_next.changed    = member_bit;
                    end
                end
                else
                begin
                    state_next     = cov_pkg::ST_IDLE;
                    out_valid_next = 1'b1;
                    out_next.kind  = cov_pkg::KIND_END;
                    out_next.last  = 1'b1;
                end
            end
            default:
            begin
                state_next = cov_pkg::ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= cov_pkg::ST_IDLE;
            change_map_reg   <= 32'd0;
            change_count_reg <= 6'd0;
            walk_reg         <= 6'd0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            change_map_reg   <= change_map_next;
            change_count_reg <= change_count_next;
            walk_reg         <= walk_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            member_count_reg <= 6'd0;
            monitor_mask_reg <= 32'd0;
            group_mode_reg   <= 3'd0;
            eps_reg[0]       <= '0;
            eps_reg[1]       <= '0;
            eps_reg[2]       <= '0;
            eps_reg[3]       <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                cov_pkg::CFG_MEMBER_COUNT: member_count_reg <= cfg_data[5:0];
                cov_pkg::CFG_MONITOR_MASK: monitor_mask_reg <= cfg_data[31:0];
                cov_pkg::CFG_GROUP_MODE:   group_mode_reg   <= cfg_data[2:0];
                cov_pkg::CFG_EPS_ZERO:     eps_reg[0]       <= cfg_data;
                cov_pkg::CFG_EPS_ONE:      eps_reg[1]       <= cfg_data;
                cov_pkg::CFG_EPS_TWO:      eps_reg[2]       <= cfg_data;
                cov_pkg::CFG_EPS_THREE:    eps_reg[3]       <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            idx_reg     <= item.member_index;
            type_reg    <= item.value_type;
            sample_reg  <= item.sample;
            sel_reg     <= item.eps_select;
            watched_reg <= in_watched;
            all_reg     <= item.report_every || !any_watched || !group_mode_reg[2];
        end
        if (state_reg == cov_pkg::ST_DIFF)
        begin
            t_reg <= rd_data[31:0];
            d_reg <= d_next;
        end
        out_reg <= out_next;
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

endmodule

// File: hdl/cov_checker.sv
// port-level checker for the change-of-value monitor, with its bind
`timescale 1ns / 1ps

module cov_checker (
    input logic             clk,
    input logic             rst_n,
    input logic             start,
    input logic             busy,
    input cov_pkg::item_t   item,
    input logic             result_valid,
    input cov_pkg::result_t result
);

    logic take;
    assign take = start && !busy;

    // a sample is answered by a single ack for the same member
    assert property (@(posedge clk) disable iff (!rst_n)
        take && (item.action == cov_pkg::ACT_SAMPLE) |-> ##3
        (result_valid && (result.kind == cov_pkg::KIND_ACK) && result.last
         && (result.member_out == $past(item.member_index, 3))))
        else $error("sample transfer without matching ack");

    // finish scan gives the count as a closing result
    assert property (@(posedge clk) disable iff (!rst_n)
        take && (item.action == cov_pkg::ACT_FINISH) |-> ##2
        (result_valid && (result.kind == cov_pkg::KIND_COUNT) && result.last))
        else $error("finish scan without count");

    // a report opens with begin, never as the last result
    assert property (@(posedge clk) disable iff (!rst_n)
        take && (item.action == cov_pkg::ACT_REPORT) |-> ##2
        (result_valid && (result.kind == cov_pkg::KIND_BEGIN) && !result.last))
        else $error("report without begin");

    // start scan stays silent and leaves the block free
    assert property (@(posedge clk) disable iff (!rst_n)
        take && (item.action == cov_pkg::ACT_START) |=> (!busy && !result_valid))
        else $error("start scan produced activity");

    // nothing follows directly on a closing result
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.last |=> !result_valid)
        else $error("result straight after a closing result");

endmodule

bind change_of_value_monitor cov_checker u_cov_checker (.*);
